>>> rtl/core/assert_macros.svh
// assertion macros shared by the span fill rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, disabled while reset is high
`define SSF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("span fill assertion failed");
// clocked check that also holds during reset
`define SSF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("span fill assertion failed");
`else
`define SSF_ASSERT(label, clk, rst, prop)
`define SSF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/ssf_pkg.sv
// shared types and constants of the scanline span fill block
`default_nettype none
package ssf_pkg;

  localparam int COORD_W = 9;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W = COORD_W + FRAC_BITS;
  localparam int CNT_W = 5;
  localparam int WALK_W = 26;
  localparam int SLOPE_W = 27;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DRAIN,
    ST_QREAD,
    ST_RESP
  } state_t;

  // table access for one cycle
  typedef struct packed {
    logic rd;
    logic merge;
    logic clr;
  } tbl_op_t;

endpackage
`default_nettype wire

>>> rtl/core/ssf_if.sv
// request and span channel interfaces
`default_nettype none
interface ssf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [8:0] edge_start_x;
  logic [8:0] edge_start_y;
  logic [8:0] edge_end_x;
  logic [8:0] edge_end_y;
  logic [8:0] query_row;

  modport source (
    output valid, req_type, edge_start_x, edge_start_y, edge_end_x, edge_end_y, query_row,
    input  ready
  );
  modport sink (
    input  valid, req_type, edge_start_x, edge_start_y, edge_end_x, edge_end_y, query_row,
    output ready
  );
endinterface

interface ssf_span_if;
  logic       valid;
  logic       ready;
  logic [8:0] span_row;
  logic [9:0] span_left;
  logic [8:0] span_right;
  logic       has_span;

  modport source (
    output valid, span_row, span_left, span_right, has_span,
    input  ready
  );
  modport sink (
    input  valid, span_row, span_left, span_right, has_span,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/core/ssf_div.sv
// restoring divider, one quotient bit per cycle, for the edge slope
`default_nettype none
`include "assert_macros.svh"
module ssf_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ssf_pkg::QUOT_W-1:0]  num,
  input  wire logic [ssf_pkg::COORD_W-1:0] den,
  output logic                             done,
  output logic [ssf_pkg::QUOT_W-1:0]       quot
);

  logic                        busy;
  logic [ssf_pkg::CNT_W-1:0]   cnt;
  logic [ssf_pkg::QUOT_W-1:0]  sr;
  logic [ssf_pkg::COORD_W-1:0] rem;
  logic [ssf_pkg::COORD_W-1:0] den_r;
  logic [ssf_pkg::COORD_W:0]   trial;
  logic                        ge;
  logic [ssf_pkg::COORD_W-1:0] rem_next;

  // one trial subtract per cycle
  always_comb begin
    trial = {rem, sr[ssf_pkg::QUOT_W-1]};
    ge = trial >= {1'b0, den_r};
    rem_next = ge ? ssf_pkg::COORD_W'(trial - {1'b0, den_r})
                  : trial[ssf_pkg::COORD_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ssf_pkg::CNT_W'(ssf_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      sr    <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      sr  <= {sr[ssf_pkg::QUOT_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quot = sr;

  `SSF_ASSERT(a_done_ends_busy, clk, rst, done |-> !busy)

endmodule
`default_nettype wire

>>> rtl/core/ssf_table.sv
// combined left/right edge table memory with row merge
`default_nettype none
`include "assert_macros.svh"
module ssf_table #(
  parameter int GRID_SIZE = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ssf_pkg::tbl_op_t       op,
  input  wire logic [((GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1)-1:0] addr,
  input  wire logic [ssf_pkg::COORD_W-1:0] xi,
  output logic [$clog2(GRID_SIZE + 1) + ssf_pkg::COORD_W - 1:0] rdata
);

  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int LW = $clog2(GRID_SIZE + 1);
  localparam int EW = LW + ssf_pkg::COORD_W;

  logic [EW-1:0] mem [GRID_SIZE];

  logic                        s1_merge;
  logic [AW-1:0]               s1_addr;
  logic [ssf_pkg::COORD_W-1:0] s1_xi;
  logic [LW-1:0]               old_left;
  logic [ssf_pkg::COORD_W-1:0] old_right;
  logic [LW-1:0]               new_left;
  logic [ssf_pkg::COORD_W-1:0] new_right;

  // widen the stored span by the edge x registered with the read in the cycle before
  always_comb begin
    old_left  = rdata[EW-1:ssf_pkg::COORD_W];
    old_right = rdata[ssf_pkg::COORD_W-1:0];
    new_left  = (32'(s1_xi) < 32'(old_left)) ? LW'(s1_xi) : old_left;
    new_right = (s1_xi > old_right) ? s1_xi : old_right;
  end

  // merge pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_merge <= 1'b0;
    end else begin
      s1_merge <= op.rd && op.merge;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr;
    s1_xi   <= xi;
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (op.rd) begin
      rdata <= mem[addr];
    end
  end

  // memory write port: clear sweep or merged write back
  always_ff @(posedge clk) begin
    if (op.clr) begin
      mem[addr] <= {LW'(GRID_SIZE), {ssf_pkg::COORD_W{1'b0}}};
    end else if (s1_merge) begin
      mem[s1_addr] <= {new_left, new_right};
    end
  end

  `SSF_ASSERT(a_no_rw_same_row, clk, rst, s1_merge && op.rd |-> addr != s1_addr)
  `SSF_ASSERT(a_no_clear_during_merge, clk, rst, s1_merge |-> !op.clr)

endmodule
`default_nettype wire

>>> rtl/core/scanline_span_fill.sv
// scanline span fill: per-row left/right edge tables for polygon filling
//
// Channels: req (sink) carries clear, edge and row-span requests; span
// (source) carries one result per row-span request. A transfer happens on
// a clock edge with valid and ready both high.
// Work per request, one request at a time:
//   clear    one table row written per cycle until every row is cleared
//   edge     no table write when horizontal; else the divider forms the
//            slope, the walk is loaded, one pipelined table
//            read-modify-write per row, then a drain state
//   row span table row read and captured, then loaded into the output
//            register; the next request is taken only after that load
// Reset starts a clearing pass through the table memory;
// req.ready stays low until it finishes.
// The result sits in an output register. A clear or edge request is taken
// and worked on while a result waits; a second row-span request waits for
// the output register before its result is loaded. Request code 3 is
// taken and dropped.
`default_nettype none
`include "assert_macros.svh"
module scanline_span_fill #(
  parameter int GRID_SIZE = 512
) (
  input wire logic   clk,
  input wire logic   rst,
  ssf_req_if.sink    req,
  ssf_span_if.source span
);

  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int LW = $clog2(GRID_SIZE + 1);
  localparam int CW = ssf_pkg::COORD_W;

  ssf_pkg::state_t  state;
  ssf_pkg::state_t  state_next;
  ssf_pkg::tbl_op_t op;
  logic [AW-1:0]    tbl_addr;
  logic [LW+CW-1:0] rdata;

  logic [AW-1:0] clr_cnt;
  logic [CW-1:0] row;
  logic [CW-1:0] y1_r;
  logic [CW-1:0] x0_r;
  logic          slope_neg;
  logic [ssf_pkg::WALK_W-1:0]  walk_x;
  logic [ssf_pkg::SLOPE_W-1:0] walk_slope;

  logic [CW-1:0] q_row;
  logic          q_in;
  logic [LW-1:0] pend_left;
  logic [CW-1:0] pend_right;
  logic          out_valid;
  logic          out_load;

  logic          swap;
  logic [CW-1:0] ox0, oy0, ox1, oy1;
  logic [CW-1:0] dy;
  logic          dx_neg;
  logic [CW-1:0] mag;
  logic          div_start;
  logic          div_done;
  logic [ssf_pkg::QUOT_W-1:0] quot;

  // order the endpoints by y and form the slope operands
  always_comb begin
    swap   = req.edge_end_y < req.edge_start_y;
    ox0    = swap ? req.edge_end_x : req.edge_start_x;
    oy0    = swap ? req.edge_end_y : req.edge_start_y;
    ox1    = swap ? req.edge_start_x : req.edge_end_x;
    oy1    = swap ? req.edge_start_y : req.edge_end_y;
    dy     = oy1 - oy0;
    dx_neg = ox1 < ox0;
    mag    = dx_neg ? ox0 - ox1 : ox1 - ox0;
  end

  ssf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag, {ssf_pkg::FRAC_BITS{1'b0}}}),
    .den   (dy),
    .done  (div_done),
    .quot  (quot)
  );

  ssf_table #(
    .GRID_SIZE (GRID_SIZE)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .addr  (tbl_addr),
    .xi    (walk_x[ssf_pkg::FRAC_BITS +: CW]),
    .rdata (rdata)
  );

  assign out_load = (state == ssf_pkg::ST_RESP) && (!out_valid || span.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssf_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and table control
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    op         = '0;
    tbl_addr   = AW'(row);
    div_start  = 1'b0;
    case (state)
      ssf_pkg::ST_CLEAR: begin
        op.clr   = 1'b1;
        tbl_addr = clr_cnt;
        if (clr_cnt == AW'(GRID_SIZE - 1)) begin
          state_next = ssf_pkg::ST_IDLE;
        end
      end
      ssf_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        tbl_addr  = AW'(req.query_row);
        if (req.valid) begin
          case (req.req_type)
            ssf_pkg::REQ_CLEAR: state_next = ssf_pkg::ST_CLEAR;
            ssf_pkg::REQ_EDGE: begin
              if (dy != '0) begin
                div_start  = 1'b1;
                state_next = ssf_pkg::ST_DIV;
              end
            end
            ssf_pkg::REQ_QUERY: begin
              op.rd      = 32'(req.query_row) < GRID_SIZE;
              state_next = ssf_pkg::ST_QREAD;
            end
            default: state_next = ssf_pkg::ST_IDLE;
          endcase
        end
      end
      ssf_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ssf_pkg::ST_WALK;
        end
      end
      ssf_pkg::ST_WALK: begin
        op.rd    = 32'(row) < GRID_SIZE;
        op.merge = 1'b1;
        if (row == CW'(y1_r - 1'b1)) begin
          state_next = ssf_pkg::ST_DRAIN;
        end
      end
      ssf_pkg::ST_DRAIN: state_next = ssf_pkg::ST_IDLE;
      ssf_pkg::ST_QREAD: state_next = ssf_pkg::ST_RESP;
      ssf_pkg::ST_RESP: begin
        if (out_load) begin
          state_next = ssf_pkg::ST_IDLE;
        end
      end
      default: state_next = ssf_pkg::ST_IDLE;
    endcase
  end

  // control registers: clear sweep, walk position, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      walk_x     <= '0;
      walk_slope <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ssf_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else if (state == ssf_pkg::ST_IDLE) begin
        clr_cnt <= '0;
      end
      if (state == ssf_pkg::ST_DIV && div_done) begin
        walk_slope <= slope_neg ? ssf_pkg::SLOPE_W'(-{2'b00, quot})
                                : ssf_pkg::SLOPE_W'({2'b00, quot});
        walk_x     <= ssf_pkg::WALK_W'({x0_r, {ssf_pkg::FRAC_BITS{1'b0}}});
      end else if (state == ssf_pkg::ST_WALK) begin
        walk_x <= walk_x + walk_slope[ssf_pkg::WALK_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (span.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request payload capture and row counter
  always_ff @(posedge clk) begin
    if (state == ssf_pkg::ST_IDLE && req.valid) begin
      row       <= oy0;
      y1_r      <= oy1;
      x0_r      <= ox0;
      slope_neg <= dx_neg;
      q_row     <= req.query_row;
      q_in      <= 32'(req.query_row) < GRID_SIZE;
    end else if (state == ssf_pkg::ST_WALK) begin
      row <= row + 1'b1;
    end
  end

  // row span capture and output register
  always_ff @(posedge clk) begin
    if (state == ssf_pkg::ST_QREAD) begin
      pend_left  <= q_in ? rdata[LW+CW-1:CW] : LW'(GRID_SIZE);
      pend_right <= q_in ? rdata[CW-1:0] : '0;
    end
    if (out_load) begin
      span.span_row   <= q_row;
      span.span_left  <= 10'(pend_left);
      span.span_right <= pend_right;
      span.has_span   <= 32'(pend_left) <= 32'(pend_right);
    end
  end

  assign span.valid = out_valid;

  `SSF_ASSERT(a_div_done_in_div, clk, rst, div_done |-> state == ssf_pkg::ST_DIV)
  `SSF_ASSERT(a_walk_below_end, clk, rst, state == ssf_pkg::ST_WALK |-> row < y1_r)
  `SSF_ASSERT(a_div_span_nonzero, clk, rst, state == ssf_pkg::ST_DIV |-> row < y1_r)
  `SSF_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> state == ssf_pkg::ST_CLEAR)

endmodule
`default_nettype wire
